/* sv/gmbfs_pkg.sv */
package gmbfs_pkg;

  // Default grid size.
  localparam int unsigned GRID_ROWS_DEF = 16;
  localparam int unsigned GRID_COLS_DEF = 16;

  // Width of the row and column fields on the request channel.
  localparam int unsigned FIELD_W = 4;

  // Request function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  // Neighbour order while a cell is expanded.
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_WEST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_EAST  = 2'd3;

  // Number of neighbour-read steps in one expansion; the step after them is the last check.
  localparam logic [2:0] NB_STEPS = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_FETCH,
    ST_EXPAND,
    ST_DONE
  } state_e;

endpackage

/* sv/gmbfs_if.sv */
interface gmbfs_in_if;
  import gmbfs_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] cell_row;
  logic [FIELD_W-1:0] cell_col;
  logic               blocked;
  logic [FIELD_W-1:0] start_row;
  logic [FIELD_W-1:0] start_col;
  logic [FIELD_W-1:0] end_row;
  logic [FIELD_W-1:0] end_col;

  modport source (
    output valid, func, cell_row, cell_col, blocked,
           start_row, start_col, end_row, end_col,
    input  ready
  );

  modport sink (
    input  valid, func, cell_row, cell_col, blocked,
           start_row, start_col, end_row, end_col,
    output ready
  );
endinterface

interface gmbfs_out_if;
  logic valid;
  logic ready;
  logic path_found;

  modport source (
    output valid, path_found,
    input  ready
  );

  modport sink (
    input  valid, path_found,
    output ready
  );
endinterface

/* sv/grid_maze_bfs_reachability_unit.sv */
// Load request: written straight into the wall map when the cell lies inside the grid.
// Solve request: a visited-map clearing pass, a seed step, then per dequeued cell
// one FIFO read, four neighbour reads and a last check on the single-read-port
// maps, and a step to post the result; a start outside the grid goes straight to posting no path.
// After reset a pass marks every cell blocked; no request is taken meanwhile.
module grid_maze_bfs_reachability_unit #(
  parameter int unsigned GRID_ROWS = gmbfs_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = gmbfs_pkg::GRID_COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gmbfs_in_if.sink          in_i,
  gmbfs_out_if.source       out_o
);
  import gmbfs_pkg::*;

  localparam int unsigned RW = $clog2(GRID_ROWS);
  localparam int unsigned CW = $clog2(GRID_COLS);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [RW:0] ROWS_L = (RW + 1)'(GRID_ROWS);
  localparam logic [CW:0] COLS_L = (CW + 1)'(GRID_COLS);
  localparam logic [7:0]  ROWS_8 = 8'(GRID_ROWS);
  localparam logic [7:0]  COLS_8 = 8'(GRID_COLS);

  // Maps addressed by {row, column}; the queue holds such addresses.
  logic          wall_mem  [DEPTH];
  logic          visit_mem [DEPTH];
  logic [AW-1:0] fifo_mem  [DEPTH];

  state_e        state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [AW:0]   head_q, head_d;
  logic [AW:0]   tail_q, tail_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] end_q, end_d;
  logic          end_in_q, end_in_d;
  logic [2:0]    nb_q, nb_d;
  logic          pend_v_q, pend_v_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          found_q, found_d;
  logic          out_valid_q, out_valid_d;
  logic          path_q, path_d;

  logic          wall_rd_q, visit_rd_q;
  logic [AW-1:0] fifo_rd_q;

  logic          wall_we, wall_wdata;
  logic [AW-1:0] wall_waddr;
  logic          visit_we, visit_wdata;
  logic [AW-1:0] visit_waddr;
  logic          fifo_we;
  logic [AW-1:0] fifo_waddr, fifo_wdata;

  logic [AW-1:0] cur_src, nb_addr;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic          nb_ok;

  logic [7:0]    cell_row_w, cell_col_w, start_row_w, start_col_w, end_row_w, end_col_w;
  logic          cell_in, start_in, end_in;
  logic [AW-1:0] cell_addr, start_addr, end_addr;
  logic          in_fire;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_fire          = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.path_found = path_q;

  // Request coordinates widened for the grid bound check, then cut to map width.
  assign cell_row_w  = {4'b0, in_i.cell_row};
  assign cell_col_w  = {4'b0, in_i.cell_col};
  assign start_row_w = {4'b0, in_i.start_row};
  assign start_col_w = {4'b0, in_i.start_col};
  assign end_row_w   = {4'b0, in_i.end_row};
  assign end_col_w   = {4'b0, in_i.end_col};
  assign cell_in     = (cell_row_w < ROWS_8) && (cell_col_w < COLS_8);
  assign start_in    = (start_row_w < ROWS_8) && (start_col_w < COLS_8);
  assign end_in      = (end_row_w < ROWS_8) && (end_col_w < COLS_8);
  assign cell_addr   = {cell_row_w[RW-1:0], cell_col_w[CW-1:0]};
  assign start_addr  = {start_row_w[RW-1:0], start_col_w[CW-1:0]};
  assign end_addr    = {end_row_w[RW-1:0], end_col_w[CW-1:0]};

  // The cell under expansion comes from the FIFO on the first step.
  assign cur_src = (nb_q == 3'd0) ? fifo_rd_q : cur_q;
  assign cur_row = cur_src[AW-1:CW];
  assign cur_col = cur_src[CW-1:0];

  // Neighbour address and grid edge check for the current direction.
  always_comb begin
    nb_addr = cur_src;
    nb_ok   = 1'b0;
    case (nb_q[1:0])
      DIR_NORTH: begin
        nb_addr = {cur_row - RW'(1), cur_col};
        nb_ok   = (cur_row != '0);
      end
      DIR_WEST: begin
        nb_addr = {cur_row, cur_col - CW'(1)};
        nb_ok   = (cur_col != '0);
      end
      DIR_SOUTH: begin
        nb_addr = {cur_row + RW'(1), cur_col};
        nb_ok   = (({1'b0, cur_row} + (RW + 1)'(1)) < ROWS_L);
      end
      default: begin
        nb_addr = {cur_row, cur_col + CW'(1)};
        nb_ok   = (({1'b0, cur_col} + (CW + 1)'(1)) < COLS_L);
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      nb_q        <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nb_q        <= nb_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    start_q     <= start_d;
    end_q       <= end_d;
    end_in_q    <= end_in_d;
    pend_addr_q <= pend_addr_d;
    found_q     <= found_d;
    path_q      <= path_d;
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    start_d     = start_q;
    end_d       = end_q;
    end_in_d    = end_in_q;
    nb_d        = nb_q;
    pend_v_d    = 1'b0;
    pend_addr_d = pend_addr_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    path_d      = path_q;
    wall_we     = 1'b0;
    wall_waddr  = cell_addr;
    wall_wdata  = in_i.blocked;
    visit_we    = 1'b0;
    visit_waddr = pend_addr_q;
    visit_wdata = 1'b1;
    fifo_we     = 1'b0;
    fifo_waddr  = tail_q[AW-1:0];
    fifo_wdata  = pend_addr_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        wall_we    = 1'b1;
        wall_waddr = sweep_q;
        wall_wdata = 1'b1;
        sweep_d    = sweep_q + AW'(1);
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.func == FUNC_LOAD) begin
            wall_we = cell_in;
          end else begin
            start_d  = start_addr;
            end_d    = end_addr;
            end_in_d = end_in;
            sweep_d  = '0;
            if (start_in) begin
              state_d = ST_CLEAR;
            end else begin
              found_d = 1'b0;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_CLEAR: begin
        visit_we    = 1'b1;
        visit_waddr = sweep_q;
        visit_wdata = 1'b0;
        sweep_d     = sweep_q + AW'(1);
        if (sweep_q == '1) begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        // The start cell is queued whether it is open or not.
        visit_we    = 1'b1;
        visit_waddr = start_q;
        fifo_we     = 1'b1;
        fifo_waddr  = '0;
        fifo_wdata  = start_q;
        head_d      = '0;
        tail_d      = (AW + 1)'(1);
        state_d     = ST_FETCH;
      end
      ST_FETCH: begin
        head_d  = head_q + (AW + 1)'(1);
        nb_d    = '0;
        state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        cur_d = cur_src;
        if (nb_q == 3'd0 && end_in_q && cur_src == end_q) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          // Check the neighbour read on the previous cycle and queue it if free.
          if (pend_v_q && !wall_rd_q && !visit_rd_q) begin
            visit_we = 1'b1;
            fifo_we  = 1'b1;
            tail_d   = tail_q + (AW + 1)'(1);
          end
          if (nb_q != NB_STEPS) begin
            pend_v_d    = nb_ok;
            pend_addr_d = nb_addr;
            nb_d        = nb_q + 3'd1;
          end else begin
            nb_d = '0;
            if (head_q == tail_d) begin
              found_d = 1'b0;
              state_d = ST_DONE;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          path_d      = found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // Wall map: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    wall_rd_q <= wall_mem[nb_addr];
  end

  // Visited map: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (visit_we) begin
      visit_mem[visit_waddr] <= visit_wdata;
    end
    visit_rd_q <= visit_mem[nb_addr];
  end

  // Search FIFO: written at the tail, read at the head.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_rd_q <= fifo_mem[head_q[AW-1:0]];
  end

endmodule

/* sv/gmbfs_checker.sv */
module gmbfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_func_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic path_found_i
);
  import gmbfs_pkg::*;

  // A result that is not taken stays offered with the same flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(path_found_i))
    else $error("result dropped or changed while stalled");

  // A solve request makes the block busy on the next cycle.
  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_SOLVE |=> !in_ready_i)
    else $error("block still ready after a solve request");

  // A load request never raises a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_LOAD && !out_valid_i |=> !out_valid_i)
    else $error("result raised by a load request");

  // A new result appears only after a solve request, while requests are held off.
  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while the block was idle");

endmodule

bind grid_maze_bfs_reachability_unit gmbfs_checker u_gmbfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .path_found_i (out_o.path_found)
);
